[hdl/ncrf_pkg.sv]
// Shared types, constants and helpers for the Newton cubic root finder.
package ncrf_pkg;

  localparam int DATA_W    = 32;
  localparam int ACC_W     = 36;
  localparam int TOL_W     = 31;
  localparam int ITER_W    = 7;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 8;

  typedef logic signed [DATA_W-1:0] fix_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  localparam fix_t FIX_MAX = 32'sh7FFF_FFFF;
  localparam fix_t FIX_MIN = 32'sh8000_0000;

  localparam logic [CFG_IDX_W-1:0] REG_COEF_SQUARE   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_LINEAR   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_CONSTANT = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE     = 8'd3;

  localparam fix_t             RST_COEF_SQUARE   = -32'sd1677722;
  localparam fix_t             RST_COEF_LINEAR   = 32'sd6710886;
  localparam fix_t             RST_COEF_CONSTANT = -32'sd25165824;
  localparam logic [TOL_W-1:0] RST_TOLERANCE     = 31'd16777;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_CONVERGED  = 2'd0,
    STATUS_ITER_LIMIT = 2'd1,
    STATUS_ZERO_SLOPE = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PX2,
    ST_PX2W,
    ST_PLIN,
    ST_PCUB,
    ST_PSQ,
    ST_PEND,
    ST_SLP0,
    ST_SLP1,
    ST_SEND,
    ST_DIV,
    ST_UPD,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    PH_START,
    PH_ALT,
    PH_UPDATE
  } phase_t;

  typedef struct packed {
    fix_t             coef_square;
    fix_t             coef_linear;
    fix_t             coef_constant;
    logic [TOL_W-1:0] tolerance;
  } cfg_t;

  typedef struct packed {
    fix_t              root;
    logic [ITER_W-1:0] iterations;
    status_t           status;
  } res_t;

  typedef struct packed {
    logic start;
    fix_t num;
    fix_t den;
  } div_req_t;

  typedef struct packed {
    logic done;
    fix_t quo;
  } div_rsp_t;

  function automatic fix_t sat_acc(acc_t v);
    fix_t r;
    if (v[ACC_W-1:DATA_W-1] == '0 || v[ACC_W-1:DATA_W-1] == '1) begin
      r = v[DATA_W-1:0];
    end else begin
      r = v[ACC_W-1] ? FIX_MIN : FIX_MAX;
    end
    return r;
  endfunction

endpackage

[hdl/ncrf_ifs.sv]
// Handshake channel interfaces: interval input, root result, register writes.
interface ncrf_in_if;
  logic               valid;
  logic               ready;
  ncrf_pkg::fix_t     interval_low;
  ncrf_pkg::fix_t     interval_high;
  modport source (output valid, output interval_low, output interval_high, input ready);
  modport sink   (input valid, input interval_low, input interval_high, output ready);
endinterface

interface ncrf_out_if;
  logic                            valid;
  logic                            ready;
  ncrf_pkg::fix_t                  root;
  logic [ncrf_pkg::ITER_W-1:0]     iterations;
  logic [ncrf_pkg::STATUS_W-1:0]   status;
  modport source (output valid, output root, output iterations, output status, input ready);
  modport sink   (input valid, input root, input iterations, input status, output ready);
endinterface

interface ncrf_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [ncrf_pkg::CFG_IDX_W-1:0]   index;
  logic [ncrf_pkg::DATA_W-1:0]      data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/ncrf_mul.sv]
// Shared fixed-point multiplier: registered product, floor scaling, saturation.
module ncrf_mul #(
  parameter int FRAC_BITS = 24
) (
  input  logic           clk,
  input  ncrf_pkg::fix_t op_a,
  input  ncrf_pkg::fix_t op_b,
  output ncrf_pkg::fix_t res
);

  logic signed [2*ncrf_pkg::DATA_W-1:0] prod;
  logic signed [2*ncrf_pkg::DATA_W-1:0] scaled;

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

  assign scaled = prod >>> FRAC_BITS;

  always_comb begin
    if (scaled[2*ncrf_pkg::DATA_W-1:ncrf_pkg::DATA_W-1] == '0 ||
        scaled[2*ncrf_pkg::DATA_W-1:ncrf_pkg::DATA_W-1] == '1) begin
      res = scaled[ncrf_pkg::DATA_W-1:0];
    end else begin
      res = scaled[2*ncrf_pkg::DATA_W-1] ? ncrf_pkg::FIX_MIN : ncrf_pkg::FIX_MAX;
    end
  end

endmodule

[hdl/ncrf_div.sv]
// Radix-2 restoring divider for (num * 2^FRAC_BITS) / den with saturation.
module ncrf_div #(
  parameter int FRAC_BITS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  ncrf_pkg::div_req_t req,
  output ncrf_pkg::div_rsp_t rsp
);

  localparam int DW = ncrf_pkg::DATA_W;
  localparam int NW = DW + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);

  logic          busy;
  logic          fin;
  logic          done;
  logic [CW-1:0] cnt;
  logic [NW-1:0] nq;
  logic [DW-1:0] rem;
  logic [DW-1:0] dmag;
  logic          neg;
  ncrf_pkg::fix_t quo;

  logic [DW:0]   rem_sh;
  logic          ge;
  logic [DW-1:0] num_mag;
  logic [DW-1:0] den_mag;
  logic          ovf_pos;
  logic          ovf_neg;

  assign rem_sh  = {rem, nq[NW-1]};
  assign ge      = rem_sh >= {1'b0, dmag};
  assign num_mag = req.num[DW-1] ? DW'(-req.num) : req.num;
  assign den_mag = req.den[DW-1] ? DW'(-req.den) : req.den;
  assign ovf_pos = |nq[NW-1:DW-1];
  assign ovf_neg = (|nq[NW-1:DW]) || (nq[DW-1] && (|nq[DW-2:0]));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= fin;
      fin  <= !req.start && busy && cnt == CW'(1);
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      nq   <= {num_mag, FRAC_BITS'(0)};
      rem  <= '0;
      dmag <= den_mag;
      neg  <= req.num[DW-1] ^ req.den[DW-1];
      cnt  <= CW'(NW);
    end else if (busy) begin
      rem <= ge ? DW'(rem_sh - {1'b0, dmag}) : rem_sh[DW-1:0];
      nq  <= {nq[NW-2:0], ge};
      cnt <= cnt - CW'(1);
    end
    if (fin) begin
      if (neg) begin
        quo <= ovf_neg ? ncrf_pkg::FIX_MIN : DW'(-nq[DW-1:0]);
      end else begin
        quo <= ovf_pos ? ncrf_pkg::FIX_MAX : nq[DW-1:0];
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;

  // divide-by-zero is filtered upstream
  a_nonzero_den: assert property (@(posedge clk) disable iff (rst) busy |-> dmag != '0)
    else $error("divider running with zero divisor");

endmodule

[hdl/ncrf_core.sv]
// Newton iteration sequencer around the shared multiplier and the divider.
module ncrf_core #(
  parameter int MAX_ITER  = 64,
  parameter int FRAC_BITS = 24
) (
  input  logic           clk,
  input  logic           rst,
  input  ncrf_pkg::cfg_t cfg,
  input  logic           in_valid,
  output logic           in_ready,
  input  ncrf_pkg::fix_t in_low,
  input  ncrf_pkg::fix_t in_high,
  output logic           res_valid,
  input  logic           res_ready,
  output ncrf_pkg::res_t res
);

  localparam int CNT_W = $clog2(MAX_ITER + 1);

  ncrf_pkg::state_t   state;
  ncrf_pkg::state_t   state_next;
  ncrf_pkg::phase_t   phase;
  ncrf_pkg::status_t  status;
  ncrf_pkg::fix_t     x;
  ncrf_pkg::fix_t     x2;
  ncrf_pkg::fix_t     f;
  ncrf_pkg::fix_t     b_end;
  ncrf_pkg::acc_t     acc;
  logic [CNT_W-1:0]   count;

  ncrf_pkg::fix_t     op_a;
  ncrf_pkg::fix_t     op_b;
  ncrf_pkg::fix_t     mres;
  ncrf_pkg::div_req_t div_req;
  ncrf_pkg::div_rsp_t div_rsp;

  ncrf_pkg::fix_t     fs;
  ncrf_pkg::acc_t     fabs;
  ncrf_pkg::acc_t     curv;
  logic               same;
  logic               conv;
  logic               at_limit;

  ncrf_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .res  (mres)
  );

  ncrf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign fs       = ncrf_pkg::sat_acc(acc);
  assign fabs     = fs[ncrf_pkg::DATA_W-1] ? -ncrf_pkg::acc_t'(fs) : ncrf_pkg::acc_t'(fs);
  assign conv     = fabs < ncrf_pkg::acc_t'(cfg.tolerance);
  assign at_limit = count >= CNT_W'(MAX_ITER);
  assign curv     = (ncrf_pkg::acc_t'(x) <<< 2) + (ncrf_pkg::acc_t'(x) <<< 1)
                  + (ncrf_pkg::acc_t'(cfg.coef_square) <<< 1);
  assign same     = (acc > 0 && curv > 0) || (acc < 0 && curv < 0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ncrf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    in_ready      = 1'b0;
    res_valid     = 1'b0;
    op_a          = x;
    op_b          = x;
    div_req.start = 1'b0;
    div_req.num   = f;
    div_req.den   = fs;
    unique case (state)
      ncrf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = ncrf_pkg::ST_PX2;
      end
      ncrf_pkg::ST_PX2:  state_next = ncrf_pkg::ST_PX2W;
      ncrf_pkg::ST_PX2W: begin
        op_a       = cfg.coef_linear;
        state_next = ncrf_pkg::ST_PLIN;
      end
      ncrf_pkg::ST_PLIN: begin
        op_a       = x2;
        state_next = ncrf_pkg::ST_PCUB;
      end
      ncrf_pkg::ST_PCUB: begin
        op_a       = cfg.coef_square;
        op_b       = x2;
        state_next = ncrf_pkg::ST_PSQ;
      end
      ncrf_pkg::ST_PSQ:  state_next = ncrf_pkg::ST_PEND;
      ncrf_pkg::ST_PEND: begin
        unique case (phase)
          ncrf_pkg::PH_START:  state_next = same ? ncrf_pkg::ST_SLP0 : ncrf_pkg::ST_PX2;
          ncrf_pkg::PH_ALT:    state_next = ncrf_pkg::ST_SLP0;
          ncrf_pkg::PH_UPDATE: begin
            state_next = (conv || at_limit) ? ncrf_pkg::ST_DONE : ncrf_pkg::ST_SLP0;
          end
          default:             state_next = ncrf_pkg::ST_IDLE;
        endcase
      end
      ncrf_pkg::ST_SLP0: begin
        op_a       = cfg.coef_square;
        state_next = ncrf_pkg::ST_SLP1;
      end
      ncrf_pkg::ST_SLP1: state_next = ncrf_pkg::ST_SEND;
      ncrf_pkg::ST_SEND: begin
        if (acc == '0) begin
          state_next = ncrf_pkg::ST_DONE;
        end else begin
          div_req.start = 1'b1;
          state_next    = ncrf_pkg::ST_DIV;
        end
      end
      ncrf_pkg::ST_DIV: begin
        if (div_rsp.done) state_next = ncrf_pkg::ST_UPD;
      end
      ncrf_pkg::ST_UPD:  state_next = ncrf_pkg::ST_PX2;
      ncrf_pkg::ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) state_next = ncrf_pkg::ST_IDLE;
      end
      default:           state_next = ncrf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      ncrf_pkg::ST_IDLE: begin
        if (in_valid) begin
          x     <= in_low;
          b_end <= in_high;
          count <= '0;
          phase <= ncrf_pkg::PH_START;
        end
      end
      ncrf_pkg::ST_PX2W: begin
        x2  <= mres;
        acc <= ncrf_pkg::acc_t'(cfg.coef_constant);
      end
      ncrf_pkg::ST_PLIN, ncrf_pkg::ST_PCUB, ncrf_pkg::ST_PSQ: begin
        acc <= acc + ncrf_pkg::acc_t'(mres);
      end
      ncrf_pkg::ST_PEND: begin
        f <= fs;
        if (phase == ncrf_pkg::PH_START && !same) begin
          x     <= b_end;
          phase <= ncrf_pkg::PH_ALT;
        end
        if (phase == ncrf_pkg::PH_UPDATE) begin
          status <= conv ? ncrf_pkg::STATUS_CONVERGED : ncrf_pkg::STATUS_ITER_LIMIT;
        end
      end
      ncrf_pkg::ST_SLP0: begin
        acc <= (ncrf_pkg::acc_t'(x2) <<< 1) + ncrf_pkg::acc_t'(x2)
             + ncrf_pkg::acc_t'(cfg.coef_linear);
      end
      ncrf_pkg::ST_SLP1: begin
        acc <= acc + (ncrf_pkg::acc_t'(mres) <<< 1);
      end
      ncrf_pkg::ST_SEND: begin
        status <= ncrf_pkg::STATUS_ZERO_SLOPE;
      end
      ncrf_pkg::ST_UPD: begin
        x     <= ncrf_pkg::sat_acc(ncrf_pkg::acc_t'(x) - ncrf_pkg::acc_t'(div_rsp.quo));
        count <= count + CNT_W'(1);
        phase <= ncrf_pkg::PH_UPDATE;
      end
      default: ;
    endcase
  end

  assign res.root       = x;
  assign res.iterations = ncrf_pkg::ITER_W'(count);
  assign res.status     = status;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    state != ncrf_pkg::ST_IDLE |-> count <= CNT_W'(MAX_ITER))
    else $error("update count past limit");

  a_upd_below_limit: assert property (@(posedge clk) disable iff (rst)
    state == ncrf_pkg::ST_UPD |-> count < CNT_W'(MAX_ITER))
    else $error("update issued at iteration limit");

  a_check_after_update: assert property (@(posedge clk) disable iff (rst)
    (state == ncrf_pkg::ST_PEND && phase == ncrf_pkg::PH_UPDATE) |-> count != '0)
    else $error("residual check without an update");

endmodule

[hdl/newton_cubic_root_finder_core.sv]
// Top level of the Newton cubic root finder: register file, core, result register.
//
// Usage:
//   item   : one beat carries an interval end pair (interval_low, interval_high),
//            signed fixed point with FRAC_BITS fraction bits.
//   result : one beat per item with root, iterations and status
//            (converged, iteration limit, zero derivative).
//   cfg    : register writes (0 x^2 coef, 1 x coef, 2 constant, 3 tolerance),
//            always ready; write only while no item is in flight.
// Flow: an item runs the start-point test (with a second evaluation if the
//   other end is chosen), then Newton updates until it converges, hits the
//   iteration limit or meets a zero slope, then hands the result off. The
//   bit-serial divider dominates each update; the four polynomial products
//   and the slope product go through one shared multiplier.
// item.ready is high only while the core is idle: one item at a time.
// Reset loads the default coefficients and tolerance and empties the result
//   register. A stalled result waits in the result register; the core may
//   take and start the next item meanwhile and holds its result until the
//   register frees.
module newton_cubic_root_finder_core #(
  parameter int MAX_ITER  = 64,
  parameter int FRAC_BITS = 24
) (
  input logic        clk,
  input logic        rst,
  ncrf_in_if.sink    item,
  ncrf_out_if.source result,
  ncrf_cfg_if.sink   cfg
);

  ncrf_pkg::cfg_t cfg_regs;
  ncrf_pkg::res_t core_res;
  ncrf_pkg::res_t out_res;
  logic           core_valid;
  logic           core_ready;
  logic           out_valid;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.coef_square   <= ncrf_pkg::RST_COEF_SQUARE;
      cfg_regs.coef_linear   <= ncrf_pkg::RST_COEF_LINEAR;
      cfg_regs.coef_constant <= ncrf_pkg::RST_COEF_CONSTANT;
      cfg_regs.tolerance     <= ncrf_pkg::RST_TOLERANCE;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        ncrf_pkg::REG_COEF_SQUARE:   cfg_regs.coef_square   <= cfg.data;
        ncrf_pkg::REG_COEF_LINEAR:   cfg_regs.coef_linear   <= cfg.data;
        ncrf_pkg::REG_COEF_CONSTANT: cfg_regs.coef_constant <= cfg.data;
        ncrf_pkg::REG_TOLERANCE:     cfg_regs.tolerance     <= cfg.data[ncrf_pkg::TOL_W-1:0];
        default: ;
      endcase
    end
  end

  ncrf_core #(
    .MAX_ITER  (MAX_ITER),
    .FRAC_BITS (FRAC_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_regs),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .in_low    (item.interval_low),
    .in_high   (item.interval_high),
    .res_valid (core_valid),
    .res_ready (core_ready),
    .res       (core_res)
  );

  assign core_ready = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (core_valid && core_ready) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (core_valid && core_ready) out_res <= core_res;
  end

  assign result.valid      = out_valid;
  assign result.root       = out_res.root;
  assign result.iterations = out_res.iterations;
  assign result.status     = out_res.status;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready) |=> !item.ready)
    else $error("second item taken while one is in progress");

endmodule

[tb/sv/testbench.sv]
// Self-checking bench for the Newton cubic root finder: directed table, then random settings.
`timescale 1ns / 100ps

module testbench;

  localparam int MAX_ITER        = 64;
  localparam int FRAC            = 24;
  localparam int LIMIT           = 4_000_000;
  localparam int N_PHASES        = 10;
  localparam int ITEMS_PER_PHASE = 21;

  localparam longint         HI32 = 2147483647;
  localparam longint         LO32 = -HI32 - 1;
  localparam ncrf_pkg::fix_t ONE  = 32'sh0100_0000;

  localparam int SET_DEF   = 0;
  localparam int SET_FLAT  = 1;
  localparam int SET_CUBE  = 2;
  localparam int SET_NOTOL = 3;
  localparam int SET_EXTA  = 4;
  localparam int SET_EXTB  = 5;

  typedef struct packed {
    logic [2:0]     set_id;
    ncrf_pkg::fix_t lo;
    ncrf_pkg::fix_t hi;
    logic           typed;
    ncrf_pkg::res_t want;
  } drow_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ncrf_in_if  item_ch ();
  ncrf_out_if result_ch ();
  ncrf_cfg_if cfg_ch ();

  newton_cubic_root_finder_core #(
    .MAX_ITER  (MAX_ITER),
    .FRAC_BITS (FRAC)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  always #10 clk = ~clk;

  ncrf_pkg::cfg_t reg_sets [6] = '{
    '{ncrf_pkg::RST_COEF_SQUARE, ncrf_pkg::RST_COEF_LINEAR, ncrf_pkg::RST_COEF_CONSTANT,
      ncrf_pkg::RST_TOLERANCE},
    '{32'sd0, 32'sd0, ONE, ncrf_pkg::RST_TOLERANCE},
    '{32'sd0, 32'sd0, 32'sd0, 31'd0},
    '{ncrf_pkg::RST_COEF_SQUARE, ncrf_pkg::RST_COEF_LINEAR, ncrf_pkg::RST_COEF_CONSTANT,
      31'd0},
    '{ncrf_pkg::FIX_MIN, ncrf_pkg::FIX_MAX, ncrf_pkg::FIX_MIN, 31'h7FFF_FFFF},
    '{ncrf_pkg::FIX_MAX, ncrf_pkg::FIX_MIN, ncrf_pkg::FIX_MAX, 31'd1}
  };

  // zero-slope rows are typed in; the rest go through the predictor
  drow_t dir_tab [22] = '{
    '{SET_DEF, 2 * ONE, 32'sd0, 1'b0, '0},
    '{SET_DEF, -2 * ONE, 32'sd0, 1'b0, '0},
    '{SET_DEF, ONE / 2, 3 * ONE / 2, 1'b0, '0},
    '{SET_DEF, ncrf_pkg::FIX_MIN, ncrf_pkg::FIX_MAX, 1'b0, '0},
    '{SET_DEF, ncrf_pkg::FIX_MAX, ncrf_pkg::FIX_MIN, 1'b0, '0},
    '{SET_DEF, 32'sd0, -32'sd1, 1'b0, '0},
    '{SET_DEF, 32'sd1, -32'sd1, 1'b0, '0},
    '{SET_DEF, ONE, ONE, 1'b0, '0},
    '{SET_FLAT, 32'sd0, 32'sd0, 1'b1, '{32'sd0, 7'd0, ncrf_pkg::STATUS_ZERO_SLOPE}},
    '{SET_FLAT, ONE, 32'sd0, 1'b0, '0},
    '{SET_FLAT, 32'sd0, ONE, 1'b0, '0},
    '{SET_FLAT, ncrf_pkg::FIX_MAX, 32'sd0, 1'b0, '0},
    '{SET_FLAT, ncrf_pkg::FIX_MIN, 32'sd0, 1'b0, '0},
    '{SET_CUBE, 32'sd0, 32'sd0, 1'b1, '{32'sd0, 7'd0, ncrf_pkg::STATUS_ZERO_SLOPE}},
    '{SET_CUBE, 32'sd0, ONE, 1'b0, '0},
    '{SET_NOTOL, ONE, 2 * ONE, 1'b0, '0},
    '{SET_EXTA, 32'sd0, ONE, 1'b0, '0},
    '{SET_EXTA, ncrf_pkg::FIX_MIN, ncrf_pkg::FIX_MAX, 1'b0, '0},
    '{SET_EXTA, 3 * ONE, -3 * ONE, 1'b0, '0},
    '{SET_EXTB, ncrf_pkg::FIX_MAX, ncrf_pkg::FIX_MIN, 1'b0, '0},
    '{SET_EXTB, -ONE, ONE, 1'b0, '0},
    '{SET_EXTB, 32'sd0, 32'sd0, 1'b0, '0}
  };

  longint sq_coef    = ncrf_pkg::RST_COEF_SQUARE;
  longint lin_coef   = ncrf_pkg::RST_COEF_LINEAR;
  longint const_coef = ncrf_pkg::RST_COEF_CONSTANT;
  longint tol_bound  = ncrf_pkg::RST_TOLERANCE;

  ncrf_pkg::res_t roots_due [$];
  int   n_errors   = 0;
  int   n_sent     = 0;
  int   n_results  = 0;
  int   n_writes   = 0;
  int   n_sets     = 0;
  int   n_conv     = 0;
  int   n_limit    = 0;
  int   n_flat     = 0;
  int   hold_cnt   = 0;
  bit   quiet      = 1'b0;

  function automatic longint clamp32(longint v);
    if (v > HI32) return HI32;
    if (v < LO32) return LO32;
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return clamp32((a * b) >>> FRAC);
  endfunction

  function automatic longint cubic_at(longint x);
    longint x2;
    longint x3;
    x2 = qmul(x, x);
    x3 = qmul(x2, x);
    return clamp32(x3 + qmul(sq_coef, x2) + qmul(lin_coef, x) + const_coef);
  endfunction

  function automatic longint slope_at(longint x);
    return clamp32(3 * qmul(x, x) + 2 * qmul(sq_coef, x) + lin_coef);
  endfunction

  function automatic ncrf_pkg::res_t solve_cubic(ncrf_pkg::fix_t lo, ncrf_pkg::fix_t hi);
    longint a;
    longint fa;
    longint ca;
    longint x;
    longint d;
    longint q;
    longint r;
    int unsigned n;
    ncrf_pkg::res_t res;
    ncrf_pkg::status_t st;
    a  = lo;
    fa = cubic_at(a);
    ca = clamp32(6 * a + 2 * sq_coef);
    x  = ((fa > 0 && ca > 0) || (fa < 0 && ca < 0)) ? a : longint'(hi);
    n  = 0;
    while (1) begin
      d = slope_at(x);
      if (d == 0) begin
        st = ncrf_pkg::STATUS_ZERO_SLOPE;
        break;
      end
      q = clamp32((cubic_at(x) * (64'sd1 <<< FRAC)) / d);
      x = clamp32(x - q);
      n++;
      r = cubic_at(x);
      if (r < 0) r = -r;
      if (r < tol_bound) begin
        st = ncrf_pkg::STATUS_CONVERGED;
        break;
      end
      if (n >= MAX_ITER) begin
        st = ncrf_pkg::STATUS_ITER_LIMIT;
        break;
      end
    end
    res.root       = x[31:0];
    res.iterations = n[ncrf_pkg::ITER_W-1:0];
    res.status     = st;
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(0, 2);
    if (r < 92) return $urandom_range(3, 12);
    return $urandom_range(30, 120);
  endfunction

  function automatic ncrf_pkg::fix_t rand_fix(longint span);
    longint r;
    r = $urandom_range(0, 32'(2 * span));
    return ncrf_pkg::fix_t'(r - span);
  endfunction

  task automatic flag(string msg);
    $display("MISMATCH at result %0d: %s", n_results, msg);
    n_errors++;
  endtask

  task automatic check_root();
    ncrf_pkg::res_t want;
    if (roots_due.size() == 0) begin
      flag("result beat with no interval pending");
      return;
    end
    want = roots_due.pop_front();
    n_results++;
    case (want.status)
      ncrf_pkg::STATUS_CONVERGED:  n_conv++;
      ncrf_pkg::STATUS_ITER_LIMIT: n_limit++;
      default:                     n_flat++;
    endcase
    if (result_ch.root !== want.root)
      flag($sformatf("root %h, want %h", result_ch.root, want.root));
    if (result_ch.iterations !== want.iterations)
      flag($sformatf("iterations %0d, want %0d", result_ch.iterations, want.iterations));
    if (result_ch.status !== want.status)
      flag($sformatf("status %0d, want %0d", result_ch.status, want.status));
  endtask

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) check_root();
    if (hold_cnt != 0) begin
      result_ch.ready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else begin
      result_ch.ready <= 1'b1;
      if (!quiet && $urandom_range(0, 5) == 0) hold_cnt <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if ($urandom_range(0, 2999) == 0) quiet <= ~quiet;
  end

  task automatic write_reg(logic [ncrf_pkg::CFG_IDX_W-1:0] idx,
                           logic [ncrf_pkg::DATA_W-1:0] data);
    repeat (1 + (quiet ? 0 : $urandom_range(0, 3))) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    n_writes++;
    case (idx)
      ncrf_pkg::REG_COEF_SQUARE:   sq_coef    = $signed(data);
      ncrf_pkg::REG_COEF_LINEAR:   lin_coef   = $signed(data);
      ncrf_pkg::REG_COEF_CONSTANT: const_coef = $signed(data);
      ncrf_pkg::REG_TOLERANCE:     tol_bound  = longint'(data[ncrf_pkg::TOL_W-1:0]);
      default: ;
    endcase
  endtask

  task automatic load_set(ncrf_pkg::cfg_t s);
    logic [ncrf_pkg::CFG_IDX_W-1:0] junk_idx;
    junk_idx = ncrf_pkg::CFG_IDX_W'($urandom_range(ncrf_pkg::REG_TOLERANCE + 1, 255));
    write_reg(ncrf_pkg::REG_COEF_SQUARE, s.coef_square);
    write_reg(ncrf_pkg::REG_COEF_LINEAR, s.coef_linear);
    write_reg(ncrf_pkg::REG_COEF_CONSTANT, s.coef_constant);
    // top bit of the tolerance write must be dropped
    write_reg(ncrf_pkg::REG_TOLERANCE, {1'($urandom_range(0, 1)), s.tolerance});
    write_reg(junk_idx, $urandom());
    n_sets++;
  endtask

  task automatic drain_roots();
    while (roots_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic send_interval(ncrf_pkg::fix_t lo, ncrf_pkg::fix_t hi, ncrf_pkg::res_t want);
    repeat (1 + (quiet ? 0 : pick_gap())) @(posedge clk);
    item_ch.valid         <= 1'b1;
    item_ch.interval_low  <= lo;
    item_ch.interval_high <= hi;
    do @(posedge clk); while (!item_ch.ready);
    item_ch.valid <= 1'b0;
    roots_due.push_back(want);
    n_sent++;
  endtask

  initial begin
    repeat (LIMIT) @(posedge clk);
    $display("[newton_cubic_root_finder_core] ERROR");
    $finish;
  end

  initial begin
    int             cur_set;
    int             pick;
    int             shape;
    ncrf_pkg::cfg_t s;
    ncrf_pkg::fix_t lo;
    ncrf_pkg::fix_t hi;
    item_ch.valid         = 1'b0;
    item_ch.interval_low  = '0;
    item_ch.interval_high = '0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.index          = '0;
    cfg_ch.data           = '0;
    result_ch.ready       = 1'b0;
    cur_set               = SET_DEF;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].set_id != cur_set) begin
        drain_roots();
        load_set(reg_sets[dir_tab[i].set_id]);
        cur_set = dir_tab[i].set_id;
      end
      send_interval(dir_tab[i].lo, dir_tab[i].hi,
                    dir_tab[i].typed ? dir_tab[i].want
                                     : solve_cubic(dir_tab[i].lo, dir_tab[i].hi));
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain_roots();
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        s.coef_square   = $urandom();
        s.coef_linear   = $urandom();
        s.coef_constant = $urandom();
        s.tolerance     = ncrf_pkg::TOL_W'($urandom());
      end else begin
        s.coef_square   = rand_fix(4 * ONE);
        s.coef_linear   = rand_fix(4 * ONE);
        s.coef_constant = rand_fix(4 * ONE);
        s.tolerance     = ncrf_pkg::TOL_W'((pick == 1) ? $urandom_range(0, 15)
                                                       : $urandom_range(256, 1 << 20));
      end
      load_set(s);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        shape = $urandom_range(0, 9);
        if (shape == 0) begin
          lo = $urandom();
          hi = $urandom();
        end else if (shape == 1) begin
          lo = $urandom_range(0, 1) ? ncrf_pkg::FIX_MAX : ncrf_pkg::FIX_MIN;
          hi = rand_fix(8 * ONE);
        end else begin
          lo = rand_fix(8 * ONE);
          hi = rand_fix(8 * ONE);
        end
        send_interval(lo, hi, solve_cubic(lo, hi));
      end
    end

    while (roots_due.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("Covered %0d intervals and %0d results over %0d register settings (%0d writes).",
             n_sent, n_results, n_sets, n_writes);
    $display("Outcomes: %0d converged, %0d iteration limit, %0d zero slope; %0d mismatches.",
             n_conv, n_limit, n_flat, n_errors);
    if (n_errors == 0) begin
      $display("[newton_cubic_root_finder_core] OK");
    end else begin
      $display("[newton_cubic_root_finder_core] ERROR");
    end
    $finish;
  end

endmodule
